FILE: src/gregu_pkg.sv
// Shared constants, types and constant functions of the gamma ramp entry generator.
`default_nettype none

package gregu_pkg;

   localparam int LQ               = 30;
   localparam int FRAC_BITS        = 12;
   localparam int MAX_RAMP_ENTRIES = 4096;
   localparam int IDX_W            = 12;
   localparam int RAMP_W           = 13;
   localparam int CFG_W            = 16;
   localparam int VAL_W            = 16;
   localparam int CSR_IDX_W        = 2;
   localparam int MANT_W           = LQ + 1;
   localparam int LOG_W            = LQ + 4;
   localparam int QUO_W            = LOG_W + FRAC_BITS;
   localparam int SH_W             = $clog2(LQ + 1);
   localparam int LOG_LAT          = LQ + 1;
   localparam int DIV_LAT          = QUO_W;

   localparam logic [RAMP_W-1:0] RAMP_ENTRIES_RST = 13'd256;
   localparam logic [CFG_W-1:0]  ONE_Q12          = 16'd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAMP_ENTRIES = 2'd0,
      CSR_CONTRAST     = 2'd1,
      CSR_BRIGHTNESS   = 2'd2,
      CSR_GAMMA        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             zero;
   } side_type;

   function automatic longint unsigned isqrt64(input longint unsigned v);
      longint unsigned x;
      longint unsigned r;
      longint unsigned b;
      x = v;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Factor 2^(-2^-k) in Q.30, built as a chain of floored square roots.
   function automatic logic [LQ-1:0] exp_const(input int k);
      longint unsigned c;
      c = longint'(1) << (LQ - 1);
      for (int i = 0; i < k; i++) begin
         c = isqrt64(c << LQ);
      end
      return LQ'(c);
   endfunction

endpackage

`default_nettype wire

FILE: src/gamma_ramp_entry_generator_unit.sv
// Top level of the gamma ramp entry generator: config registers and the value pipeline.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_entry_index
//   rsp      out        rsp_valid / rsp_stall  rsp_ramp_value, rsp_echoed_index
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One item enters per cycle unless a stalled result holds the pipeline.
// The pipeline holds the 30 squaring stages of the log2 units, the 46 bit stages of the
// divider and the 30 multiply stages of the exp2 chain, with setup registers before and output registers after.
// Synchronous reset clears all valid bits and loads the default register values.
// A stalled result freezes the whole pipeline, and req_stall follows at once.
`default_nettype none

module gamma_ramp_entry_generator_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [gregu_pkg::IDX_W-1:0]     req_entry_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [gregu_pkg::VAL_W-1:0]     rsp_ramp_value,
   output logic      [gregu_pkg::IDX_W-1:0]     rsp_echoed_index,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [gregu_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gregu_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int LQ     = gregu_pkg::LQ;
   localparam int MW     = gregu_pkg::MANT_W;
   localparam int LW     = gregu_pkg::LOG_W;
   localparam int QW     = gregu_pkg::QUO_W;
   localparam int RW     = gregu_pkg::RAMP_W;
   localparam int GW     = gregu_pkg::CFG_W;
   localparam int IW     = gregu_pkg::IDX_W;
   localparam int VW     = gregu_pkg::VAL_W;
   localparam int SW     = gregu_pkg::SH_W;
   localparam int P_W    = GW + MW;
   localparam int V_W    = P_W + 1;
   localparam int ONE_B  = gregu_pkg::FRAC_BITS + LQ;
   localparam int D_LOG  = gregu_pkg::LOG_LAT;
   localparam int D_D    = D_LOG + 1;
   localparam int D_Q    = D_D + gregu_pkg::DIV_LAT;
   localparam int D_SH   = D_Q + LQ + 1;
   localparam int D_MUL  = D_SH + 1;
   localparam int D_ADD  = D_MUL + 1;
   localparam int D_OUT  = D_ADD + 1;

   logic [RW-1:0] ramp_entries_ff;
   logic [GW-1:0] contrast_ff;
   logic [GW-1:0] brightness_ff;
   logic [GW-1:0] gamma_ff;

   logic [RW-1:0] n_eff;
   logic [RW-1:0] last;
   logic [GW-1:0] gamma_eff;
   logic          adv;

   gregu_pkg::side_type side_in;
   gregu_pkg::side_type side_ff [0:D_OUT];
   logic [D_OUT:0]      valid_ff;

   logic [LW-1:0] log_last;
   logic [LW-1:0] log_idx;
   logic [LW-1:0] d_in;
   logic [LW-1:0] d_ff;
   logic [QW-1:0] quotient;

   logic [MW-1:0] y_ff  [1:LQ];
   logic [LQ-1:0] f_ff  [1:LQ-1];
   logic [SW-1:0] sh_ff [1:LQ];
   logic          uf_ff [1:LQ];

   logic [MW-1:0]      y_sh_in;
   logic [MW-1:0]      y_sh_ff;
   logic [P_W-1:0]     p_ff;
   logic [V_W-1:0]     v_sum;
   logic               sat_in;
   logic               low_in;
   logic               sat_ff;
   logic               low_ff;
   logic [ONE_B-1:0]   w_ff;
   logic [ONE_B+VW-1:0] scaled;
   logic [VW-1:0]      ramp_value_in;
   logic [VW-1:0]      ramp_value_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_entries_ff <= gregu_pkg::RAMP_ENTRIES_RST;
         contrast_ff     <= gregu_pkg::ONE_Q12;
         brightness_ff   <= gregu_pkg::ONE_Q12;
         gamma_ff        <= gregu_pkg::ONE_Q12;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gregu_pkg::CSR_RAMP_ENTRIES: ramp_entries_ff <= csr_wdata[RW-1:0];
            gregu_pkg::CSR_CONTRAST:     contrast_ff     <= csr_wdata;
            gregu_pkg::CSR_BRIGHTNESS:   brightness_ff   <= csr_wdata;
            gregu_pkg::CSR_GAMMA:        gamma_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (ramp_entries_ff < RW'(2)) begin
         n_eff = RW'(2);
      end else if (ramp_entries_ff > RW'(gregu_pkg::MAX_RAMP_ENTRIES)) begin
         n_eff = RW'(gregu_pkg::MAX_RAMP_ENTRIES);
      end else begin
         n_eff = ramp_entries_ff;
      end
      last      = n_eff - RW'(1);
      gamma_eff = (gamma_ff == '0) ? GW'(1) : gamma_ff;

      if ({1'b0, req_entry_index} > last) begin
         side_in.idx = last[IW-1:0];
      end else begin
         side_in.idx = req_entry_index;
      end
      side_in.zero = (side_in.idx == '0);
   end

   // The whole pipeline moves together whenever the output register can take a value.
   assign adv       = !valid_ff[D_OUT] || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[D_OUT-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i <= D_OUT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Logarithms of the last position and of this item's position.
   gregu_log2 u_log_last (
      .clock    (clock),
      .adv      (adv),
      .in_value (last),
      .log_q    (log_last)
   );

   gregu_log2 u_log_idx (
      .clock    (clock),
      .adv      (adv),
      .in_value (RW'(side_ff[0].idx)),
      .log_q    (log_idx)
   );

   assign d_in = (log_last > log_idx) ? (log_last - log_idx) : '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in;
      end
   end

   gregu_div u_div (
      .clock    (clock),
      .adv      (adv),
      .in_d     (d_ff),
      .divisor  (gamma_eff),
      .quotient (quotient)
   );

   // 2^-e: one constant factor per fraction bit, then a shift by the integer part.
   for (genvar k = 1; k <= LQ; k++) begin : g_exp
      localparam logic [LQ-1:0] EXP_C = gregu_pkg::exp_const(k);

      logic [MW-1:0]    y_p;
      logic [LQ-1:0]    f_p;
      logic [SW-1:0]    sh_p;
      logic             uf_p;
      logic [MW+LQ-1:0] prod;
      logic [MW-1:0]    y_in;

      if (k == 1) begin : g_first
         assign y_p  = MW'(1) << LQ;
         assign f_p  = quotient[LQ-1:0];
         assign sh_p = quotient[LQ+SW-1:LQ];
         assign uf_p = quotient[QW-1:LQ] > (QW-LQ)'(LQ);
      end else begin : g_next
         assign y_p  = y_ff[k-1];
         assign f_p  = f_ff[k-1];
         assign sh_p = sh_ff[k-1];
         assign uf_p = uf_ff[k-1];
      end

      always_comb begin
         prod = y_p * EXP_C;
         y_in = f_p[LQ-k] ? prod[LQ+MW-1:LQ] : y_p;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            y_ff[k]  <= y_in;
            sh_ff[k] <= sh_p;
            uf_ff[k] <= uf_p;
         end
      end

      if (k < LQ) begin : g_f
         always_ff @(posedge clock) begin
            if (adv) begin
               f_ff[k] <= f_p;
            end
         end
      end
   end

   // Position zero and an exponent past the Q.30 range both give a curve value of zero.
   assign y_sh_in = (uf_ff[LQ] || side_ff[D_SH-1].zero) ? '0 : (y_ff[LQ] >> sh_ff[LQ]);

   always_comb begin
      v_sum  = V_W'(p_ff) + (V_W'(brightness_ff) << LQ);
      sat_in = (v_sum[V_W-1:ONE_B+1] != '0);
      low_in = (v_sum <= (V_W'(1) << ONE_B));
   end

   always_comb begin
      scaled = {w_ff, VW'(0)} - (ONE_B+VW)'(w_ff);
      if (sat_ff) begin
         ramp_value_in = '1;
      end else if (low_ff) begin
         ramp_value_in = '0;
      end else begin
         ramp_value_in = scaled[ONE_B+VW-1:ONE_B];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_sh_ff       <= y_sh_in;
         p_ff          <= contrast_ff * y_sh_ff;
         sat_ff        <= sat_in;
         low_ff        <= low_in;
         w_ff          <= v_sum[ONE_B-1:0];
         ramp_value_ff <= ramp_value_in;
      end
   end

   assign rsp_valid        = valid_ff[D_OUT];
   assign rsp_ramp_value   = ramp_value_ff;
   assign rsp_echoed_index = side_ff[D_OUT].idx;

`ifndef ASSERT_OFF
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("valid bits not cleared by reset");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (adv && valid_ff[D_OUT-1]) |=> valid_ff[D_OUT])
      else $error("item lost before the output register");

   a_hold_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline moved while frozen");

   a_curve_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[D_SH] |-> (y_sh_ff <= (MW'(1) << LQ)))
      else $error("curve value above one");
`endif

endmodule

`default_nettype wire

FILE: src/gregu_log2.sv
// Pipelined log2 in Q.30 by repeated squaring of the normalized mantissa.
`default_nettype none

module gregu_log2 (
   input  wire logic                         clock,
   input  wire logic                         adv,
   input  wire logic [gregu_pkg::RAMP_W-1:0] in_value,
   output logic      [gregu_pkg::LOG_W-1:0]  log_q
);

   localparam int LQ    = gregu_pkg::LQ;
   localparam int MW    = gregu_pkg::MANT_W;
   localparam int LW    = gregu_pkg::LOG_W;
   localparam int RW    = gregu_pkg::RAMP_W;
   localparam int MSB_W = $clog2(RW);

   logic [MSB_W-1:0]    msb;
   logic [gregu_pkg::SH_W-1:0] norm_sh;
   logic [MW-1:0]       m0_in;
   logic [LW-1:0]       res0_in;
   logic [MW-1:0]       m_ff [0:LQ-1];
   logic [LW-1:0]       res_ff [0:LQ];

   always_comb begin
      msb = '0;
      for (int b = 0; b < RW; b++) begin
         if (in_value[b]) msb = MSB_W'(b);
      end
      norm_sh = gregu_pkg::SH_W'(LQ) - gregu_pkg::SH_W'(msb);
      m0_in   = MW'(in_value) << norm_sh;
      res0_in = LW'(msb) << LQ;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff[0]   <= m0_in;
         res_ff[0] <= res0_in;
      end
   end

   for (genvar i = 1; i <= LQ; i++) begin : g_sq
      logic [2*MW-1:0] prod;
      logic [MW:0]     sq;
      logic [MW-1:0]   m_in;
      logic [LW-1:0]   res_in;

      always_comb begin
         prod = m_ff[i-1] * m_ff[i-1];
         sq   = prod[LQ+MW:LQ];
         // A square of two or more sets this fraction bit and renormalizes.
         if (sq[MW]) begin
            m_in   = sq[MW:1];
            res_in = res_ff[i-1] | (LW'(1) << (LQ - i));
         end else begin
            m_in   = sq[MW-1:0];
            res_in = res_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            res_ff[i] <= res_in;
         end
      end

      if (i < LQ) begin : g_m
         always_ff @(posedge clock) begin
            if (adv) begin
               m_ff[i] <= m_in;
            end
         end
      end
   end

   assign log_q = res_ff[LQ];

endmodule

`default_nettype wire

FILE: src/gregu_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module gregu_div (
   input  wire logic                        clock,
   input  wire logic                        adv,
   input  wire logic [gregu_pkg::LOG_W-1:0] in_d,
   input  wire logic [gregu_pkg::CFG_W-1:0] divisor,
   output logic      [gregu_pkg::QUO_W-1:0] quotient
);

   localparam int QW = gregu_pkg::QUO_W;
   localparam int GW = gregu_pkg::CFG_W;

   logic [QW-1:0] num0;
   logic [GW-1:0] rem_ff [0:QW-2];
   logic [QW-1:0] num_ff [0:QW-2];
   logic [QW-1:0] quo_ff [0:QW-1];

   assign num0 = {in_d, gregu_pkg::FRAC_BITS'(0)};

   for (genvar j = 0; j < QW; j++) begin : g_bit
      logic [GW-1:0] rem_p;
      logic [QW-1:0] num_p;
      logic [QW-1:0] quo_p;
      logic [GW:0]   trial;
      logic [GW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_p = '0;
         assign num_p = num0;
         assign quo_p = '0;
      end else begin : g_next
         assign rem_p = rem_ff[j-1];
         assign num_p = num_ff[j-1];
         assign quo_p = quo_ff[j-1];
      end

      always_comb begin
         trial = {rem_p, num_p[QW-1-j]};
         if (trial >= {1'b0, divisor}) begin
            rem_in = GW'(trial - {1'b0, divisor});
            quo_in = quo_p | (QW'(1) << (QW - 1 - j));
         end else begin
            rem_in = trial[GW-1:0];
            quo_in = quo_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[j] <= quo_in;
         end
      end

      if (j < QW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j] <= rem_in;
               num_ff[j] <= num_p;
            end
         end
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule

`default_nettype wire

FILE: test/tb_gamma_ramp_entry_generator_unit.sv
// Testbench of the gamma ramp entry generator: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb_gamma_ramp_entry_generator_unit;

   localparam int FRAC_Q = 30;
   localparam int DRAIN_CYCLES = 130;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic [gregu_pkg::VAL_W-1:0] value;
      logic [gregu_pkg::IDX_W-1:0] index;
   } ramp_entry_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [gregu_pkg::IDX_W-1:0] req_entry_index;
   logic rsp_valid;
   logic rsp_stall;
   logic [gregu_pkg::VAL_W-1:0] rsp_ramp_value;
   logic [gregu_pkg::IDX_W-1:0] rsp_echoed_index;
   logic csr_valid;
   logic csr_ready;
   logic [gregu_pkg::CSR_IDX_W-1:0] csr_index;
   logic [gregu_pkg::CFG_W-1:0] csr_wdata;

   // Shadow copies of the configuration registers.
   logic [gregu_pkg::RAMP_W-1:0] cur_entries;
   logic [gregu_pkg::CFG_W-1:0] cur_contrast;
   logic [gregu_pkg::CFG_W-1:0] cur_brightness;
   logic [gregu_pkg::CFG_W-1:0] cur_gamma;

   longint unsigned exp_chain [0:FRAC_Q];
   ramp_entry_type expected_entries [$];
   int error_count;
   int idle_pct;
   int stall_pct;
   int quiet_cycles;

   gamma_ramp_entry_generator_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_entry_index(req_entry_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ramp_value(rsp_ramp_value),
      .rsp_echoed_index(rsp_echoed_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Base-2 logarithm in Q.30 by repeated squaring of the normalized mantissa.
   function automatic longint unsigned log2_fixed(input longint unsigned v);
      int k;
      longint unsigned m;
      longint unsigned res;
      k = 0;
      while (k < 62 && (v >> (k + 1)) != 0) k++;
      if (k > FRAC_Q) k = FRAC_Q;
      m = v << (FRAC_Q - k);
      res = longint'(k) << FRAC_Q;
      for (int i = FRAC_Q - 1; i >= 0; i--) begin
         m = (m * m) >> FRAC_Q;
         if (m >= (longint'(2) << FRAC_Q)) begin
            m = m >> 1;
            res = res | (longint'(1) << i);
         end
      end
      return res;
   endfunction

   function automatic longint unsigned pow2_neg_fixed(input longint unsigned e);
      longint unsigned ip;
      longint unsigned y;
      ip = e >> FRAC_Q;
      y = longint'(1) << FRAC_Q;
      if (ip > FRAC_Q) return 0;
      for (int k = 1; k <= FRAC_Q; k++) begin
         if ((e >> (FRAC_Q - k)) & 1) y = (y * exp_chain[k]) >> FRAC_Q;
      end
      return y >> ip;
   endfunction

   function automatic ramp_entry_type ramp_value_of(
      input logic [gregu_pkg::IDX_W-1:0] raw_index);
      ramp_entry_type r;
      longint unsigned n;
      longint unsigned idx;
      longint unsigned y;
      longint unsigned d;
      longint unsigned g;
      longint unsigned v;
      longint unsigned w;
      longint unsigned one;
      longint unsigned la;
      longint unsigned lb;
      longint unsigned res;
      n = cur_entries;
      if (n < 2) n = 2;
      if (n > gregu_pkg::MAX_RAMP_ENTRIES) n = gregu_pkg::MAX_RAMP_ENTRIES;
      idx = raw_index;
      if (idx > n - 1) idx = n - 1;
      if (idx == 0) begin
         y = 0;
      end else begin
         la = log2_fixed(n - 1);
         lb = log2_fixed(idx);
         d = (la > lb) ? la - lb : 0;
         g = (cur_gamma != 0) ? cur_gamma : 1;
         y = pow2_neg_fixed((d << gregu_pkg::FRAC_BITS) / g);
      end
      one = longint'(1) << (gregu_pkg::FRAC_BITS + FRAC_Q);
      v = longint'(cur_contrast) * y + (longint'(cur_brightness) << FRAC_Q);
      if (v <= one) begin
         res = 0;
      end else begin
         w = v - one;
         if (w >= one) res = 65535;
         else res = (w * 65535) >> (gregu_pkg::FRAC_BITS + FRAC_Q);
      end
      r.value = gregu_pkg::VAL_W'(res);
      r.index = gregu_pkg::IDX_W'(idx);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Result checker: every accepted result is matched against the oldest prediction.
   always @(posedge clock) begin
      ramp_entry_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_entries.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d index %0d",
                                      rsp_ramp_value, rsp_echoed_index));
         end else begin
            e = expected_entries.pop_front();
            if (rsp_ramp_value !== e.value)
               report_mismatch($sformatf("ramp_value %0d, predicted %0d (index %0d)",
                                         rsp_ramp_value, e.value, e.index));
            if (rsp_echoed_index !== e.index)
               report_mismatch($sformatf("echoed_index %0d, predicted %0d",
                                         rsp_echoed_index, e.index));
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_gamma_ramp_entry_generator_unit: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input logic [gregu_pkg::IDX_W-1:0] index);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_entry_index <= index;
      do @(posedge clock); while (req_stall);
      expected_entries.push_back(ramp_value_of(index));
      @(negedge clock);
   endtask

   task automatic wait_idle;
      req_valid <= 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after its last write.
   task automatic write_csr(input gregu_pkg::csr_index_type which,
                            input logic [gregu_pkg::CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (which)
         gregu_pkg::CSR_RAMP_ENTRIES: cur_entries = data[gregu_pkg::RAMP_W-1:0];
         gregu_pkg::CSR_CONTRAST:     cur_contrast = data;
         gregu_pkg::CSR_BRIGHTNESS:   cur_brightness = data;
         gregu_pkg::CSR_GAMMA:        cur_gamma = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input logic [gregu_pkg::CFG_W-1:0] entries,
                             input logic [gregu_pkg::CFG_W-1:0] con,
                             input logic [gregu_pkg::CFG_W-1:0] bri,
                             input logic [gregu_pkg::CFG_W-1:0] gam);
      wait_idle();
      write_csr(gregu_pkg::CSR_RAMP_ENTRIES, entries);
      write_csr(gregu_pkg::CSR_CONTRAST, con);
      write_csr(gregu_pkg::CSR_BRIGHTNESS, bri);
      write_csr(gregu_pkg::CSR_GAMMA, gam);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults;
      send_item(12'd0);
      send_item(12'd1);
      send_item(12'd128);
      send_item(12'd255);
      send_item(12'd256);
      send_item(12'hFFF);
   endtask

   task automatic test_ramp_sizes;
      set_config(16'd0, gregu_pkg::ONE_Q12, gregu_pkg::ONE_Q12, gregu_pkg::ONE_Q12);
      send_item(12'd1);
      send_item(12'd2);
      set_config(16'd4096, 16'd8192, gregu_pkg::ONE_Q12, 16'd9011);
      send_item(12'd1);
      send_item(12'd2048);
      send_item(12'hFFF);
      set_config(16'h1FFF, gregu_pkg::ONE_Q12, 16'd2048, 16'd2048);
      send_item(12'd4094);
      send_item(12'hAAA);
   endtask

   task automatic test_gamma_extremes;
      // A gamma of zero acts as one and pushes the exponent of index 1 past its range, so y is zero there.
      set_config(16'd4096, 16'hFFFF, gregu_pkg::ONE_Q12, 16'd0);
      send_item(12'd1);
      send_item(12'd4094);
      set_config(16'd4096, gregu_pkg::ONE_Q12, gregu_pkg::ONE_Q12, 16'd1);
      send_item(12'd1);
      send_item(12'd4095);
      set_config(16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(12'd0);
      send_item(12'd1);
      set_config(16'd1000, 16'd0, 16'd0, 16'hFFFF);
      send_item(12'd500);
      send_item(12'd999);
      set_config(16'd1000, 16'd6000, 16'd1000, 16'd18000);
      send_item(12'd3);
      send_item(12'd555);
   endtask

   task automatic random_config;
      logic [gregu_pkg::CFG_W-1:0] entries;
      logic [gregu_pkg::CFG_W-1:0] gam;
      case ($urandom_range(4))
         0: entries = gregu_pkg::CFG_W'($urandom_range(2, 16));
         1: entries = 16'd4096;
         2: entries = gregu_pkg::CFG_W'($urandom_range(0, 65535));
         default: entries = gregu_pkg::CFG_W'($urandom_range(2, 4096));
      endcase
      if ($urandom_range(2) == 0) gam = gregu_pkg::CFG_W'($urandom_range(0, 65535));
      else gam = gregu_pkg::CFG_W'($urandom_range(1024, 16384));
      set_config(entries, gregu_pkg::CFG_W'($urandom_range(0, 65535)),
                 gregu_pkg::CFG_W'($urandom_range(0, 65535)), gam);
   endtask

   task automatic test_random_phase(input int idle, input int stall, input bit pause_midway);
      int n;
      idle_pct = idle;
      stall_pct = stall;
      for (int blk = 0; blk < 5; blk++) begin
         random_config();
         for (int i = 0; i < 70; i++) begin
            n = (cur_entries < 2) ? 2 : int'(cur_entries);
            if ($urandom_range(3) == 0)
               send_item(gregu_pkg::IDX_W'($urandom_range(0, 4095)));
            else
               send_item(gregu_pkg::IDX_W'($urandom_range(0, (n > 4096) ? 4095 : n - 1)));
            if (pause_midway && blk == 2 && i == 35) wait_idle();
         end
      end
   endtask

   initial begin
      exp_chain[0] = longint'(1) << (FRAC_Q - 1);
      for (int k = 1; k <= FRAC_Q; k++) exp_chain[k] = floor_sqrt(exp_chain[k-1] << FRAC_Q);
      cur_entries = gregu_pkg::RAMP_ENTRIES_RST;
      cur_contrast = gregu_pkg::ONE_Q12;
      cur_brightness = gregu_pkg::ONE_Q12;
      cur_gamma = gregu_pkg::ONE_Q12;
      error_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_entry_index = '0;
      csr_valid = 1'b0;
      csr_index = gregu_pkg::CSR_RAMP_ENTRIES;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_ramp_sizes();
      test_gamma_extremes();
      test_random_phase(0, 0, 1'b0);
      test_random_phase(56, 0, 1'b1);
      test_random_phase(0, 56, 1'b0);
      test_random_phase(9, 9, 1'b0);

      wait_idle();
      if (error_count == 0) begin
         $display("tb_gamma_ramp_entry_generator_unit: clean");
      end else begin
         $display("tb_gamma_ramp_entry_generator_unit: errors");
      end
      $finish;
   end

endmodule
